@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// implication checked every clock, muted during reset
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication checked every clock, muted during reset
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

@@ rtl/core/bta_pkg.sv @@
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the boundary tag allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

    localparam int POOL_BYTES_DEF = 512;
    localparam int TAG_BYTES_DEF  = 8;

    localparam int IN_W  = 24;
    localparam int OUT_W = 16;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [11:0] {
        ST_INIT = 12'b000000000001,
        ST_IDLE = 12'b000000000010,
        ST_CLR0 = 12'b000000000100,
        ST_CLR1 = 12'b000000001000,
        ST_ARD  = 12'b000000010000,
        ST_ACHK = 12'b000000100000,
        ST_FRH  = 12'b000001000000,
        ST_FDH  = 12'b000010000000,
        ST_FDF  = 12'b000100000000,
        ST_FDP  = 12'b001000000000,
        ST_FDN  = 12'b010000000000,
        ST_WR   = 12'b100000000000
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/boundary_tag_first_fit_allocator_core.sv @@
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_core
// First-fit byte pool allocator with header and footer tags per chunk.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one request beat: action, req_size, free_addr.
//   Master stream returns one beat per request: ok, addr.
//   One request is in flight at a time; s_axis_tready is low while it works
//   and while its result beat waits for m_axis_tready.
//   Tags live in a RAM with separate read and write addresses and a registered read.
//   Steps from acceptance to m_axis_tvalid: allocate reads and checks each
//   chunk header in turn, then writes the tag slots on a hit; free reads
//   header, footer, previous footer and next header, then writes the tag
//   slots, or stops when the footer falls outside the pool; clear writes
//   both tags; for an unknown action or a free address out of range the
//   beat is valid in the next cycle. Reset, with ready low: a pass zeroes
//   all POOL_BYTES tags, one per cycle, then writes the single free chunk.
//   A stalled receiver holds the result beat and blocks the next request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module boundary_tag_first_fit_allocator_core #(
    parameter int POOL_BYTES = bta_pkg::POOL_BYTES_DEF,
    parameter int TAG_BYTES  = bta_pkg::TAG_BYTES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    // action[1:0], req_size[10:2], free_addr[19:11], zero pad
    input  wire  [bta_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire                       m_axis_tready,
    // ok[0], addr[9:1], zero pad
    output logic [bta_pkg::OUT_W-1:0] m_axis_tdata
);
    import bta_pkg::*;

    localparam int PW    = $clog2(POOL_BYTES);
    localparam int AW    = ((PW > 9) ? PW : 9) + 2;
    localparam int NSLOT = 6;
    localparam int KW    = 3;

    localparam logic [AW-1:0] C_T    = AW'(TAG_BYTES);
    localparam logic [AW-1:0] C_T2   = AW'(2 * TAG_BYTES);
    localparam logic [AW-1:0] C_POOL = AW'(POOL_BYTES);
    localparam logic [PW-1:0] C_LAST = PW'(POOL_BYTES - 1);
    localparam logic [PW-1:0] C_CSZ  = PW'(POOL_BYTES - 2 * TAG_BYTES);
    localparam logic [PW-1:0] C_FTR  = PW'(POOL_BYTES - TAG_BYTES);

    logic [PW:0]    r_mem [POOL_BYTES];
    logic [PW:0]    r_rd;
    logic           mem_we;
    logic [PW-1:0]  mem_wa;
    logic [PW:0]    mem_wd;
    logic [PW-1:0]  mem_ra;

    t_state         r_state;
    logic [PW-1:0]  r_cnt;
    logic [AW-1:0]  r_i;
    logic [8:0]     r_want;
    logic [AW-1:0]  r_a;
    logic [PW-1:0]  r_h, r_f, r_s, r_hc, r_sc;
    logic           r_pv, r_nv;
    logic [NSLOT-1:0] r_wv;
    logic [PW-1:0]  r_wa [NSLOT];
    logic [PW:0]    r_wd [NSLOT];
    logic [KW-1:0]  r_wk;
    logic           r_ov, r_ok;
    logic [8:0]     r_addr;

    logic [PW-1:0]  rd_sz;
    logic           rd_fr;
    logic [AW-1:0]  sz, want, ni, f_c, nh_c, nf_c, ns_c, ns2_c;
    logic           hit, split, pm, nm;
    logic           acc;
    logic [1:0]     in_act;
    logic [8:0]     in_req, in_fa;

    assign rd_sz  = r_rd[PW-1:0];
    assign rd_fr  = r_rd[PW];
    assign in_act = s_axis_tdata[1:0];
    assign in_req = s_axis_tdata[10:2];
    assign in_fa  = s_axis_tdata[19:11];

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ov;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_W - 10){1'b0}}, r_addr, r_ok};

    always_comb begin
        sz    = AW'(rd_sz);
        want  = AW'(r_want);
        hit   = rd_fr && (sz >= want) && (r_i + sz + C_T2 <= C_POOL);
        split = sz > want + C_T2;
        ni    = r_i + sz + C_T2;
        f_c   = r_a + sz;
        nh_c  = AW'(r_f) + C_T;
        pm    = r_pv && rd_fr && (AW'(r_h) >= sz + C_T2);
        ns_c  = AW'(r_s) + sz + C_T2;
        nf_c  = nh_c + sz + C_T;
        nm    = r_nv && rd_fr && (nf_c + C_T <= C_POOL);
        ns2_c = AW'(r_sc) + sz + C_T2;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        unique case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
            end
            ST_CLR0: begin
                mem_we = 1'b1;
                mem_wd = {1'b1, C_CSZ};
            end
            ST_CLR1: begin
                mem_we = 1'b1;
                mem_wa = C_FTR;
                mem_wd = {1'b1, C_CSZ};
            end
            ST_ARD:  mem_ra = r_i[PW-1:0];
            ST_FRH:  mem_ra = PW'(r_a - C_T);
            ST_FDH:  mem_ra = f_c[PW-1:0];
            ST_FDF:  mem_ra = PW'(AW'(r_h) - C_T);
            ST_FDP:  mem_ra = nh_c[PW-1:0];
            ST_WR: begin
                mem_we = r_wv[r_wk];
                mem_wa = r_wa[r_wk];
                mem_wd = r_wd[r_wk];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_wv    <= '0;
            r_wk    <= '0;
        end else begin
            if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                // r_cnt stays nonzero after the pass, so CLR1 sends no beat
                ST_INIT: begin
                    if (r_cnt == C_LAST) begin
                        r_state <= ST_CLR0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        r_want <= in_req;
                        r_a    <= AW'(in_fa);
                        r_i    <= '0;
                        r_ok   <= 1'b0;
                        r_addr <= '0;
                        unique case (in_act)
                            ACT_ALLOC: r_state <= ST_ARD;
                            ACT_FREE: begin
                                if (AW'(in_fa) < C_T || AW'(in_fa) >= C_POOL) begin
                                    r_ov <= 1'b1;
                                end else begin
                                    r_state <= ST_FRH;
                                end
                            end
                            ACT_CLEAR: r_state <= ST_CLR0;
                            default:   r_ov <= 1'b1;
                        endcase
                    end
                end
                ST_CLR0: r_state <= ST_CLR1;
                ST_CLR1: begin
                    if (r_cnt == '0) begin
                        r_ok <= 1'b1;
                        r_ov <= 1'b1;
                    end
                    r_cnt   <= '0;
                    r_state <= ST_IDLE;
                end
                ST_ARD: r_state <= ST_ACHK;
                ST_ACHK: begin
                    if (hit) begin
                        r_ok   <= 1'b1;
                        r_addr <= 9'(r_i + C_T);
                        r_wk   <= '0;
                        if (split) begin
                            r_wv    <= 6'b001111;
                            r_wa[0] <= PW'(r_i + want + C_T2);
                            r_wd[0] <= {1'b1, PW'(sz - want - C_T2)};
                            r_wa[1] <= PW'(r_i + sz + C_T);
                            r_wd[1] <= {1'b1, PW'(sz - want - C_T2)};
                            r_wa[2] <= r_i[PW-1:0];
                            r_wd[2] <= {1'b0, PW'(want)};
                            r_wa[3] <= PW'(r_i + want + C_T);
                            r_wd[3] <= {1'b0, PW'(want)};
                        end else begin
                            r_wv    <= 6'b000011;
                            r_wa[0] <= r_i[PW-1:0];
                            r_wd[0] <= {1'b0, rd_sz};
                            r_wa[1] <= PW'(r_i + sz + C_T);
                            r_wd[1] <= {1'b0, rd_sz};
                        end
                        r_state <= ST_WR;
                    end else if (ni >= C_POOL) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_i     <= ni;
                        r_state <= ST_ARD;
                    end
                end
                ST_FRH: begin
                    r_h     <= PW'(r_a - C_T);
                    r_state <= ST_FDH;
                end
                ST_FDH: begin
                    if (f_c + C_T > C_POOL) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_s     <= rd_sz;
                        r_f     <= f_c[PW-1:0];
                        r_state <= ST_FDF;
                    end
                end
                ST_FDF: begin
                    r_wv    <= 6'b000011;
                    r_wa[0] <= r_h;
                    r_wd[0] <= {1'b1, r_s};
                    r_wa[1] <= r_f;
                    r_wd[1] <= {1'b1, rd_sz};
                    r_pv    <= AW'(r_h) >= C_T2;
                    r_state <= ST_FDP;
                end
                ST_FDP: begin
                    if (pm) begin
                        r_wv[3:2] <= 2'b11;
                        r_wa[2]   <= PW'(AW'(r_h) - sz - C_T2);
                        r_wd[2]   <= {1'b1, PW'(ns_c)};
                        r_wa[3]   <= r_f;
                        r_wd[3]   <= {1'b1, PW'(ns_c)};
                        r_hc      <= PW'(AW'(r_h) - sz - C_T2);
                        r_sc      <= PW'(ns_c);
                    end else begin
                        r_hc <= r_h;
                        r_sc <= r_s;
                    end
                    r_nv    <= nh_c + C_T2 <= C_POOL;
                    r_state <= ST_FDN;
                end
                ST_FDN: begin
                    if (nm) begin
                        r_wv[5:4] <= 2'b11;
                        r_wa[4]   <= r_hc;
                        r_wd[4]   <= {1'b1, PW'(ns2_c)};
                        r_wa[5]   <= nf_c[PW-1:0];
                        r_wd[5]   <= {1'b1, PW'(ns2_c)};
                    end
                    r_ok    <= 1'b1;
                    r_wk    <= '0;
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    r_wk <= r_wk + 1'b1;
                    if (r_wk == KW'(NSLOT - 1)) begin
                        r_wv    <= '0;
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_INIT;
            endcase
        end
    end

    `ASSERT_IMPL(a_rdy_no_out, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `ASSERT_IMPL(a_we_state, i_clk, i_rst_n, mem_we,
        r_state == ST_INIT || r_state == ST_CLR0 || r_state == ST_CLR1 || r_state == ST_WR)
    `ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, acc, !s_axis_tready)

endmodule

`default_nettype wire
